// ----- hw/rtl/sms_pkg.sv -----
// Shared types and constants for the safety mode supervisor.
`timescale 1ns / 1ps

package sms_pkg;

	// Action codes carried in the input tuser
	typedef enum logic [1:0] {
		ACT_OBSERVE = 2'd0,
		ACT_COMMIT  = 2'd1,
		ACT_FORCE   = 2'd2,
		ACT_SPARE   = 2'd3
	} action_t;

	// Reason codes reported in the result
	typedef enum logic [2:0] {
		RSN_NONE         = 3'd0,
		RSN_DISCONNECT   = 3'd1,
		RSN_MEAS_LOST    = 3'd2,
		RSN_SHORT        = 3'd3,
		RSN_LOW_RESERVE  = 3'd4,
		RSN_MODE_TIMEOUT = 3'd5,
		RSN_SESSION      = 3'd6
	} reason_t;

	// Configuration register indexes
	localparam logic CFG_SESSION_TIMEOUT = 1'b0;
	localparam logic CFG_MODE_LIMIT      = 1'b1;

	// Register reset values
	localparam logic [31:0] SESSION_TIMEOUT_RST = 32'd30000;
	localparam logic [31:0] MODE_LIMIT_RST      = 32'd60000;
	localparam logic [31:0] REVISION_RST        = 32'd1;

	// Rounding-up offset and reciprocal for x / 1000 over 32-bit x:
	// floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT
	localparam logic [31:0] ROUND_UP_MS = 32'd999;
	localparam logic [31:0] RECIP_1000  = 32'd274877907;
	localparam int          RECIP_SHIFT = 38;

	// Width of the seconds field
	localparam int SECS_W = 16;

endpackage

// ----- hw/rtl/safety_mode_supervisor.sv -----
// Safety mode supervisor: mode state, deadline, revision and reason reporting.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream (s_axis_*): one transaction per supervisor tick, carrying the
//   action in tuser and the time stamp, status flags and last activity time
//   in tdata. Output stream (m_axis_*): one result transaction per input, in
//   order, with both reasons, the held mode, the revision and seconds left.
//   Configuration: cfg_we writes cfg_data into the register cfg_index names;
//   write only while no transaction is in flight.
// Pipeline: the result passes the input register, then the state update and
//   reason logic into the stage 2 register, then the reciprocal multiply for
//   the seconds count into the output register.
// Throughput: one transaction per cycle while the output is not stalled. The
//   held mode, deadline and revision are updated by combinational logic in the
//   second stage, so consecutive items chain without bubbles.
// Reset: arst_n clears the pipeline and sets mode normal, no deadline,
//   revision 1, and the configuration registers to 30000 ms and 60000 ms.
// Stall: each stage holds while the one after it is full and stalled; empty
//   stages keep filling, so input is still taken while a result waits.
//
module safety_mode_supervisor
	import sms_pkg::*;
#(
	parameter int HIGHEST_MODE = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: target_mode[3:0], now_ms[35:4], connected[36], meas_ok[37],
	//        short_fault[38], low_energy[39], authenticated[40],
	//        last_activity_ms[72:41], zero fill [79:73]
	input  logic [79:0] s_axis_tdata,
	// tuser: action[1:0]
	input  logic [1:0]  s_axis_tuser,
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: admission_reason[2:0], required_reason[5:3], current_safe_mode[9:6],
	//        revision_out[41:10], seconds_left[57:42], zero fill [63:58]
	output logic [63:0] m_axis_tdata,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [3:0] MAX_MODE = 4'(HIGHEST_MODE);

	// Configuration registers
	logic [31:0] session_timeout_q;
	logic [31:0] mode_limit_q;

	// Supervisor state
	logic [3:0]  held_mode_q;
	logic [31:0] deadline_q;
	logic [31:0] revision_q;

	// Stage 1: registered input
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [3:0]  target_s1;
	logic [31:0] now_s1;
	logic        connected_s1;
	logic        meas_ready_s1;
	logic        short_s1;
	logic        low_energy_s1;
	logic        auth_s1;
	logic [31:0] last_act_s1;

	// Stage 2: reasons, state after the action, remaining time plus rounding
	logic        valid_s2;
	reason_t     admit_s2;
	reason_t     need_s2;
	logic [3:0]  mode_s2;
	logic [31:0] revision_s2;
	logic [31:0] rem_s2;

	// Output register
	logic        out_valid_q;
	logic [63:0] out_data_q;

	// Stage enables
	logic en_out;
	logic en_s2;
	logic en_s1;

	assign en_out        = !out_valid_q || m_axis_tready;
	assign en_s2         = !valid_s2 || en_out;
	assign en_s1         = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_timeout_q <= SESSION_TIMEOUT_RST;
			mode_limit_q      <= MODE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SESSION_TIMEOUT: session_timeout_q <= cfg_data;
				CFG_MODE_LIMIT:      mode_limit_q      <= cfg_data;
				default:             ;
			endcase
		end
	end

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			action_s1     <= s_axis_tuser;
			target_s1     <= s_axis_tdata[3:0];
			now_s1        <= s_axis_tdata[35:4];
			connected_s1  <= s_axis_tdata[36];
			meas_ready_s1 <= s_axis_tdata[37];
			short_s1      <= s_axis_tdata[38];
			low_energy_s1 <= s_axis_tdata[39];
			auth_s1       <= s_axis_tdata[40];
			last_act_s1   <= s_axis_tdata[72:41];
		end
	end

	// Stage 2 logic: reasons and state update
	reason_t     phys;
	reason_t     admit;
	reason_t     need;
	logic [31:0] sess_diff;
	logic        sess_gone;
	logic        tgt_ok;
	logic        do_commit;
	logic        do_force;
	logic [3:0]  mode_nxt;
	logic [31:0] deadline_nxt;
	logic [31:0] revision_nxt;
	logic [31:0] dl_diff;
	logic        dl_reached;
	logic [31:0] rem_nxt;

	always_comb begin
		// physical reasons by fixed priority
		if (!connected_s1)       phys = RSN_DISCONNECT;
		else if (!meas_ready_s1) phys = RSN_MEAS_LOST;
		else if (short_s1)       phys = RSN_SHORT;
		else if (low_energy_s1)  phys = RSN_LOW_RESERVE;
		else                     phys = RSN_NONE;

		// session expired when not authenticated or once now reaches last activity plus timeout
		sess_diff = now_s1 - last_act_s1 - session_timeout_q;
		sess_gone = !auth_s1 || !sess_diff[31];

		tgt_ok = (target_s1 <= MAX_MODE);

		// invalid target reports measurement lost
		if (!tgt_ok)                  admit = RSN_MEAS_LOST;
		else if (target_s1 == 4'd0)   admit = RSN_NONE;
		else if (phys != RSN_NONE)    admit = phys;
		else if (sess_gone)           admit = RSN_SESSION;
		else                          admit = RSN_NONE;

		// action; unused code acts as observe
		do_commit = (action_s1 == ACT_COMMIT) && tgt_ok;
		do_force  = (action_s1 == ACT_FORCE);

		if (do_commit) begin
			mode_nxt     = target_s1;
			deadline_nxt = (target_s1 == 4'd0) ? 32'd0 : now_s1 + mode_limit_q;
		end else if (do_force) begin
			mode_nxt     = 4'd0;
			deadline_nxt = 32'd0;
		end else begin
			mode_nxt     = held_mode_q;
			deadline_nxt = deadline_q;
		end
		revision_nxt = revision_q + {31'd0, (mode_nxt != held_mode_q)};

		// deadline compare on the wrapped difference
		dl_diff    = now_s1 - deadline_nxt;
		dl_reached = !dl_diff[31];

		if (mode_nxt == 4'd0)                          need = RSN_NONE;
		else if (phys != RSN_NONE)                     need = phys;
		else if (deadline_nxt != 32'd0 && dl_reached)  need = RSN_MODE_TIMEOUT;
		else if (sess_gone)                            need = RSN_SESSION;
		else                                           need = RSN_NONE;

		// remaining ms plus rounding offset; zero gives zero seconds
		if (mode_nxt != 4'd0 && deadline_nxt != 32'd0 && !dl_reached)
			rem_nxt = (deadline_nxt - now_s1) + ROUND_UP_MS;
		else
			rem_nxt = 32'd0;
	end

	// State registers and stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mode_q <= 4'd0;
			deadline_q  <= 32'd0;
			revision_q  <= REVISION_RST;
			valid_s2    <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				held_mode_q <= mode_nxt;
				deadline_q  <= deadline_nxt;
				revision_q  <= revision_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			admit_s2    <= admit;
			need_s2     <= need;
			mode_s2     <= mode_nxt;
			revision_s2 <= revision_nxt;
			rem_s2      <= rem_nxt;
		end
	end

	// Output stage: divide by 1000 through the reciprocal
	logic [63:0]       prod;
	logic [SECS_W-1:0] secs;

	assign prod = {32'd0, rem_s2} * {32'd0, RECIP_1000};
	assign secs = prod[RECIP_SHIFT +: SECS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			out_data_q <= {6'd0, secs, revision_s2, mode_s2, need_s2, admit_s2};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
